### design/u8dm_pkg.sv
// Shared types, constants and glyph tables for the UTF-8 to 5x7 glyph row block.
// Used by u8dm_front, u8dm_queue, u8dm_back and the top level.
package u8dm_pkg;

  localparam int GLYPH_ROWS = 7;
  localparam logic [5:0] GLYPH_UNKNOWN = 6'd42;
  localparam logic [2:0] LAST_ROW = 3'd6;
  localparam logic [7:0] CHAR_QMARK = 8'h3F;

  // Lead byte classes
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;

  // One queued step: the glyph of its final character, and whether a '?'
  // character goes before it.
  typedef struct packed {
    logic [5:0] glyph;
    logic       umlaut;
    logic       two_chars;
  } char_ent_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       umlaut;
  } folded_t;

  // Fold a code point to the glyph character set.
  function automatic folded_t fold_char(input logic [15:0] c);
    folded_t f;
    f.umlaut = 1'b0;
    f.ch     = CHAR_QMARK[6:0];
    if (c[15:7] == 9'd0) begin
      if (c[6:0] >= 7'h61 && c[6:0] <= 7'h7A) begin
        f.ch = c[6:0] - 7'h20;
      end else begin
        f.ch = c[6:0];
      end
    end else if (c[15:8] == 8'd0) begin
      case (c[7:0]) inside
        8'hC4, 8'hE4: begin f.ch = 7'h41; f.umlaut = 1'b1; end
        8'hD6, 8'hF6: begin f.ch = 7'h4F; f.umlaut = 1'b1; end
        8'hDC, 8'hFC: begin f.ch = 7'h55; f.umlaut = 1'b1; end
        [8'hC0:8'hC5], [8'hE0:8'hE5]: f.ch = 7'h41;
        8'hC7, 8'hE7: f.ch = 7'h43;
        [8'hC8:8'hCB], [8'hE8:8'hEB]: f.ch = 7'h45;
        [8'hCC:8'hCF], [8'hEC:8'hEF]: f.ch = 7'h49;
        8'hD1, 8'hF1: f.ch = 7'h4E;
        [8'hD2:8'hD6], [8'hF2:8'hF6]: f.ch = 7'h4F;
        [8'hD9:8'hDC], [8'hF9:8'hFC]: f.ch = 7'h55;
        default: f.ch = CHAR_QMARK[6:0];
      endcase
    end
    return f;
  endfunction

  // Character to glyph number; GLYPH_UNKNOWN when there is no glyph.
  function automatic logic [5:0] glyph_index(input logic [6:0] ch);
    logic [5:0] idx;
    idx = GLYPH_UNKNOWN;
    if (ch >= 7'h41 && ch <= 7'h5A) begin
      idx = 6'(ch - 7'h41);
    end else if (ch >= 7'h30 && ch <= 7'h39) begin
      idx = 6'(ch - 7'h30) + 6'd26;
    end else begin
      case (ch)
        7'h2E:   idx = 6'd36;
        7'h3A:   idx = 6'd37;
        7'h2D:   idx = 6'd38;
        7'h2F:   idx = 6'd39;
        7'h25:   idx = 6'd40;
        7'h20:   idx = 6'd41;
        default: idx = GLYPH_UNKNOWN;
      endcase
    end
    return idx;
  endfunction

  // Glyph bitmap, top row first.
  function automatic logic [0:6][4:0] glyph_bitmap(input logic [5:0] idx);
    logic [0:6][4:0] r;
    case (idx)
      6'd0:  r = {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      6'd1:  r = {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30};
      6'd2:  r = {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14};
      6'd3:  r = {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30};
      6'd4:  r = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
      6'd5:  r = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
      6'd6:  r = {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15};
      6'd7:  r = {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      6'd8:  r = {5'd14, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
      6'd9:  r = {5'd7,  5'd2,  5'd2,  5'd2,  5'd18, 5'd18, 5'd12};
      6'd10: r = {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17};
      6'd11: r = {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
      6'd12: r = {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
      6'd13: r = {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
      6'd14: r = {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      6'd15: r = {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
      6'd16: r = {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13};
      6'd17: r = {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
      6'd18: r = {5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30};
      6'd19: r = {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4};
      6'd20: r = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      6'd21: r = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
      6'd22: r = {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10};
      6'd23: r = {5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17};
      6'd24: r = {5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4};
      6'd25: r = {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31};
      6'd26: r = {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
      6'd27: r = {5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
      6'd28: r = {5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31};
      6'd29: r = {5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30};
      6'd30: r = {5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2};
      6'd31: r = {5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30};
      6'd32: r = {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
      6'd33: r = {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8};
      6'd34: r = {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
      6'd35: r = {5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14};
      6'd36: r = {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd12, 5'd12};
      6'd37: r = {5'd0,  5'd12, 5'd12, 5'd0,  5'd12, 5'd12, 5'd0};
      6'd38: r = {5'd0,  5'd0,  5'd0,  5'd31, 5'd0,  5'd0,  5'd0};
      6'd39: r = {5'd1,  5'd2,  5'd2,  5'd4,  5'd8,  5'd8,  5'd16};
      6'd40: r = {5'd17, 5'd2,  5'd4,  5'd8,  5'd16, 5'd0,  5'd17};
      6'd41: r = {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0};
      default: r = {5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd0, 5'd4};
    endcase
    return r;
  endfunction

endpackage

### design/utf8_to_dot_matrix_glyph_rows.sv
// UTF-8 text bytes to 5x7 dot-matrix glyph rows, one row per output transfer.
// Each entry passes through the character queue and the row sequencer before its first row
// is registered onto m_tdata. The back end sends one glyph row per cycle while m_tready
// allows, seven rows per character (fourteen for a byte that emits two); the input takes a
// byte per cycle while the character queue has room. Synchronous reset clears the
// decoder, the queue and the output register.
module utf8_to_dot_matrix_glyph_rows #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic        s_tlast,   // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [4:0] row_bits, [7:5] row_index, [8] umlaut_dots
  output logic        m_tlast    // last_row
);

  logic                q_push, q_full, q_pop, q_valid;
  u8dm_pkg::char_ent_t q_push_ent, q_head;
  logic                in_xfer;

  assign s_tready = !q_full;
  assign in_xfer  = s_tvalid && s_tready;

  u8dm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_xfer),
    .text_byte   (s_tdata),
    .end_of_text (s_tlast),
    .push        (q_push),
    .push_ent    (q_push_ent)
  );

  u8dm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_ent (q_push_ent),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  u8dm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // A step always ends on the bottom row of a glyph
  a_last_on_bottom: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[7:5] == u8dm_pkg::LAST_ROW)
    else $error("last row flagged off the bottom glyph row");

  // Rows of a glyph follow each other in order, none skipped or repeated
  a_row_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tdata[7:5] != u8dm_pkg::LAST_ROW |=>
      !m_tvalid || m_tdata[7:5] == 3'($past(m_tdata[7:5]) + 3'd1))
    else $error("glyph row skipped or repeated");

  // Queue never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("character queue overflow");

endmodule

### design/u8dm_front.sv
// Front end: UTF-8 sequence decoder and character folding.
// Produces one queue entry per byte that emits characters. Uses u8dm_pkg.
module u8dm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          text_byte,
  input  logic                end_of_text,
  output logic                push,
  output u8dm_pkg::char_ent_t push_ent
);

  logic [15:0] partial_code, partial_code_next;
  logic [1:0]  bytes_needed, bytes_needed_next;
  logic [1:0]  bytes_held, bytes_held_next;

  logic [7:0]  lead;
  logic        emit;
  logic        two_chars;
  logic [15:0] cp;
  u8dm_pkg::folded_t folded;

  assign lead = partial_code[15:8];

  // Decode one byte against the pending sequence
  always_comb begin
    partial_code_next = partial_code;
    bytes_needed_next = bytes_needed;
    bytes_held_next   = bytes_held;
    emit      = 1'b0;
    two_chars = 1'b0;
    cp        = {8'd0, u8dm_pkg::CHAR_QMARK};
    if (bytes_needed == 2'd1 && bytes_held == 2'd1) begin
      emit = 1'b1;
      cp   = {5'd0, lead[4:0], text_byte[5:0]};
      partial_code_next = '0;
      bytes_needed_next = '0;
      bytes_held_next   = '0;
    end else if (bytes_needed == 2'd1 && bytes_held == 2'd2) begin
      emit = 1'b1;
      cp   = {lead[3:0], partial_code[5:0], text_byte[5:0]};
      partial_code_next = '0;
      bytes_needed_next = '0;
      bytes_held_next   = '0;
    end else if (bytes_needed == 2'd2 && bytes_held == 2'd1) begin
      if (end_of_text) begin
        // held lead gives '?', the second byte is retried as a lead byte
        emit      = 1'b1;
        two_chars = 1'b1;
        cp = text_byte[7] ? {8'd0, u8dm_pkg::CHAR_QMARK} : {8'd0, text_byte};
      end else begin
        partial_code_next = {lead, text_byte};
        bytes_needed_next = 2'd1;
        bytes_held_next   = 2'd2;
      end
    end else begin
      partial_code_next = '0;
      bytes_needed_next = '0;
      bytes_held_next   = '0;
      if (!text_byte[7]) begin
        emit = 1'b1;
        cp   = {8'd0, text_byte};
      end else if ((text_byte & u8dm_pkg::LEAD2_MASK) == u8dm_pkg::LEAD2_CODE ||
                   (text_byte & u8dm_pkg::LEAD3_MASK) == u8dm_pkg::LEAD3_CODE) begin
        if (end_of_text) begin
          emit = 1'b1;
        end else begin
          partial_code_next = {text_byte, 8'd0};
          bytes_needed_next =
            ((text_byte & u8dm_pkg::LEAD2_MASK) == u8dm_pkg::LEAD2_CODE) ? 2'd1 : 2'd2;
          bytes_held_next   = 2'd1;
        end
      end else begin
        // bad lead byte
        emit = 1'b1;
      end
    end
    if (end_of_text) begin
      partial_code_next = '0;
      bytes_needed_next = '0;
      bytes_held_next   = '0;
    end
  end

  // Fold and look up the glyph of the final character
  assign folded             = u8dm_pkg::fold_char(cp);
  assign push               = accept && emit;
  assign push_ent.glyph     = u8dm_pkg::glyph_index(folded.ch);
  assign push_ent.umlaut    = folded.umlaut;
  assign push_ent.two_chars = two_chars;

  // Decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      partial_code <= '0;
      bytes_needed <= '0;
      bytes_held   <= '0;
    end else if (accept) begin
      partial_code <= partial_code_next;
      bytes_needed <= bytes_needed_next;
      bytes_held   <= bytes_held_next;
    end
  end

endmodule

### design/u8dm_queue.sv
// Small register queue of decoded character entries between front and back.
// Uses u8dm_pkg for the entry type.
module u8dm_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  u8dm_pkg::char_ent_t push_ent,
  output logic                full,
  input  logic                pop,
  output logic                valid,
  output u8dm_pkg::char_ent_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  u8dm_pkg::char_ent_t entries [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign valid = (count != '0);
  assign head  = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_ent;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

### design/u8dm_back.sv
// Back end: walks the seven rows of each queued character into an output register.
// Uses u8dm_pkg for the entry type and glyph tables.
module u8dm_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  u8dm_pkg::char_ent_t q_head,
  output logic                q_pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [15:0]         m_tdata,
  output logic                m_tlast
);

  logic       active;
  logic [5:0] glyph;
  logic       umlaut;
  logic       first_q;   // emitting the leading '?' of a two-character step
  logic [2:0] row;

  logic [4:0] out_bits;
  logic [2:0] out_row;
  logic       out_uml;

  logic       out_ready, emit, row_end, finishing;
  logic [0:6][4:0] bitmap;

  assign out_ready = !m_tvalid || m_tready;
  assign emit      = active && out_ready;
  assign row_end   = (row == u8dm_pkg::LAST_ROW);
  assign finishing = emit && row_end && !first_q;
  assign q_pop     = (!active || finishing) && q_valid;
  assign bitmap    = u8dm_pkg::glyph_bitmap(first_q ? u8dm_pkg::GLYPH_UNKNOWN : glyph);

  // Row sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      first_q <= 1'b0;
      row     <= '0;
    end else if (q_pop) begin
      active  <= 1'b1;
      first_q <= q_head.two_chars;
      row     <= '0;
    end else if (finishing) begin
      active <= 1'b0;
    end else if (emit) begin
      if (row_end) begin
        row     <= '0;
        first_q <= 1'b0;
      end else begin
        row <= row + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      glyph  <= q_head.glyph;
      umlaut <= q_head.umlaut;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_bits <= bitmap[row];
      out_row  <= row;
      out_uml  <= umlaut && !first_q;
      m_tlast  <= row_end && !first_q;
    end
  end

  assign m_tdata = {7'd0, out_uml, out_row, out_bits};

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for utf8_to_dot_matrix_glyph_rows: UTF-8 bytes in, glyph rows out.
// Uses u8dm_pkg for shared constants; predicts every row locally and compares on each transfer.
module tb_top;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_item_t;

  typedef struct packed {
    logic [4:0] pixels;
    logic [2:0] row;
    logic       dots;
    logic       final_row;
  } glyph_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;

  text_item_t  text_bytes_pending[$];
  glyph_row_t  glyph_rows_due[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  logic        calm;

  // decoder copy: held lead (and second byte), continuation bytes still due, bytes held
  logic [15:0] seq_code = 16'h0000;
  logic [1:0]  seq_need = 2'd0;
  logic [1:0]  seq_held = 2'd0;

  utf8_to_dot_matrix_glyph_rows u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #6 clk = ~clk;

  // no idling on either side inside this window
  always @(posedge clk) cycle_count <= cycle_count + 1;
  assign calm = (cycle_count >= 1500) && (cycle_count < 2600);

  // Fold a code point into the glyph character set; umlaut set for A/O/U with diaeresis
  function automatic logic [7:0] fold_to_glyph_char(input int unsigned cp, output logic umlaut);
    umlaut = 1'b0;
    if (cp >= 32'h61 && cp <= 32'h7A) return 8'(cp - 32'h20);
    if (cp < 32'h80) return 8'(cp);
    if (cp == 32'hC4 || cp == 32'hE4) begin umlaut = 1'b1; return "A"; end
    if (cp == 32'hD6 || cp == 32'hF6) begin umlaut = 1'b1; return "O"; end
    if (cp == 32'hDC || cp == 32'hFC) begin umlaut = 1'b1; return "U"; end
    if (cp > 32'hFF) return u8dm_pkg::CHAR_QMARK;
    // Latin-1: lower and upper accented forms differ only in bit 5
    cp = cp & 32'hDF;
    if (cp >= 32'hC0 && cp <= 32'hC5) return "A";
    if (cp == 32'hC7) return "C";
    if (cp >= 32'hC8 && cp <= 32'hCB) return "E";
    if (cp >= 32'hCC && cp <= 32'hCF) return "I";
    if (cp == 32'hD1) return "N";
    if (cp >= 32'hD2 && cp <= 32'hD6) return "O";
    if (cp >= 32'hD9 && cp <= 32'hDC) return "U";
    return u8dm_pkg::CHAR_QMARK;
  endfunction

  // 5x7 bitmaps, row 0 in the top five bits
  function automatic logic [34:0] glyph_rows_of(input logic [7:0] ch);
    case (ch)
      "A": return {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      "B": return {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30};
      "C": return {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14};
      "D": return {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30};
      "E": return {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
      "F": return {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
      "G": return {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15};
      "H": return {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      "I": return {5'd14, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
      "J": return {5'd7,  5'd2,  5'd2,  5'd2,  5'd18, 5'd18, 5'd12};
      "K": return {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17};
      "L": return {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
      "M": return {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
      "N": return {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
      "O": return {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      "P": return {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
      "Q": return {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13};
      "R": return {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
      "S": return {5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30};
      "T": return {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4};
      "U": return {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      "V": return {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
      "W": return {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10};
      "X": return {5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17};
      "Y": return {5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4};
      "Z": return {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31};
      "0": return {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
      "1": return {5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
      "2": return {5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31};
      "3": return {5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30};
      "4": return {5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2};
      "5": return {5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30};
      "6": return {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
      "7": return {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8};
      "8": return {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
      "9": return {5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14};
      ".": return {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd12, 5'd12};
      ":": return {5'd0,  5'd12, 5'd12, 5'd0,  5'd12, 5'd12, 5'd0};
      "-": return {5'd0,  5'd0,  5'd0,  5'd31, 5'd0,  5'd0,  5'd0};
      "/": return {5'd1,  5'd2,  5'd2,  5'd4,  5'd8,  5'd8,  5'd16};
      "%": return {5'd17, 5'd2,  5'd4,  5'd8,  5'd16, 5'd0,  5'd17};
      " ": return {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0};
      default: return {5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd0, 5'd4};
    endcase
  endfunction

  // Queue the seven rows of one character; ends_step flags the step's final row
  task automatic push_glyph_rows(input int unsigned cp, input logic ends_step);
    logic       umlaut;
    logic [7:0] ch;
    logic [34:0] bitmap;
    glyph_row_t r;
    ch = fold_to_glyph_char(cp, umlaut);
    bitmap = glyph_rows_of(ch);
    for (int i = 0; i < u8dm_pkg::GLYPH_ROWS; i++) begin
      r.pixels    = bitmap[34 - 5 * i -: 5];
      r.row       = 3'(i);
      r.dots      = umlaut;
      r.final_row = ends_step && (i == u8dm_pkg::GLYPH_ROWS - 1);
      glyph_rows_due.push_back(r);
    end
  endtask

  // Advance the decoder copy by one accepted byte and queue the rows it yields
  task automatic decode_text_byte(input logic [7:0] b, input logic eot);
    logic [7:0] lead;
    lead = seq_code[15:8];
    if (seq_need == 2'd1 && seq_held == 2'd1) begin
      push_glyph_rows(32'({lead[4:0], b[5:0]}), 1'b1);
      seq_code = 16'h0000; seq_need = 2'd0; seq_held = 2'd0;
    end else if (seq_need == 2'd1 && seq_held == 2'd2) begin
      push_glyph_rows(32'({lead[3:0], seq_code[5:0], b[5:0]}), 1'b1);
      seq_code = 16'h0000; seq_need = 2'd0; seq_held = 2'd0;
    end else if (seq_need == 2'd2 && seq_held == 2'd1) begin
      if (eot) begin
        // truncated three-byte sequence: '?' for the lead, then the second byte on its own
        push_glyph_rows(32'(u8dm_pkg::CHAR_QMARK), 1'b0);
        push_glyph_rows(32'(b < 8'h80 ? b : u8dm_pkg::CHAR_QMARK), 1'b1);
      end else begin
        seq_code = {lead, b}; seq_need = 2'd1; seq_held = 2'd2;
      end
    end else begin
      seq_code = 16'h0000; seq_need = 2'd0; seq_held = 2'd0;
      if (b < 8'h80) begin
        push_glyph_rows(32'(b), 1'b1);
      end else if ((b & u8dm_pkg::LEAD2_MASK) == u8dm_pkg::LEAD2_CODE ||
                   (b & u8dm_pkg::LEAD3_MASK) == u8dm_pkg::LEAD3_CODE) begin
        if (eot) begin
          push_glyph_rows(32'(u8dm_pkg::CHAR_QMARK), 1'b1);
        end else begin
          seq_code = {b, 8'h00};
          seq_need = ((b & u8dm_pkg::LEAD2_MASK) == u8dm_pkg::LEAD2_CODE) ? 2'd1 : 2'd2;
          seq_held = 2'd1;
        end
      end else begin
        push_glyph_rows(32'(u8dm_pkg::CHAR_QMARK), 1'b1);
      end
    end
    if (eot) begin
      seq_code = 16'h0000; seq_need = 2'd0; seq_held = 2'd0;
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) $display("%0t mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic eot);
    text_item_t t;
    t.text_byte   = b;
    t.end_of_text = eot;
    text_bytes_pending.push_back(t);
  endtask

  // One random text: mostly well-formed characters, some noise and truncation
  task automatic queue_random_text(inout int unsigned n_items);
    logic [7:0] txt[$];
    logic [7:0] punct[16];
    int unsigned n_chars;
    int unsigned pick;
    logic        cut;
    punct = '{".", ":", "-", "/", "%", " ", "0", "1", "2", "3", "4", "5", "6", "7", "8", "9"};
    n_chars = $urandom_range(1, 10);
    cut = 1'b0;
    for (int k = 0; k < n_chars && !cut; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        txt.push_back(8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? 8'h61 : 8'h41));
      end else if (pick < 45) begin
        txt.push_back(punct[$urandom_range(0, 15)]);
      end else if (pick < 55) begin
        txt.push_back(8'($urandom_range(1, 127)));
      end else if (pick < 78) begin
        // Latin-1 range
        txt.push_back($urandom_range(0, 1) ? 8'hC3 : 8'hC2);
        txt.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else if (pick < 86) begin
        txt.push_back(8'($urandom_range(8'hE0, 8'hEF)));
        txt.push_back(8'($urandom));
        txt.push_back(8'($urandom));
      end else if (pick < 91) begin
        txt.push_back(8'($urandom_range(8'hC0, 8'hDF)));
        txt.push_back(8'($urandom));
      end else if (pick < 96) begin
        // stray continuation byte or 0xF0..0xFF lead
        txt.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                           : 8'($urandom_range(8'hF0, 8'hFF)));
      end else begin
        // text ends in the middle of a sequence
        txt.push_back(8'($urandom_range(8'hC0, 8'hEF)));
        if (txt[$] >= 8'hE0 && $urandom_range(0, 1)) txt.push_back(8'($urandom));
        cut = 1'b1;
      end
    end
    foreach (txt[i]) queue_byte(txt[i], i == txt.size() - 1);
    n_items += txt.size();
  endtask

  // Driver: holds an offered byte until its transfer, then offers the next one
  always @(posedge clk) begin
    text_item_t t;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) decode_text_byte(s_tdata, s_tlast);
      if (!s_tvalid || s_tready) begin
        if (text_bytes_pending.size() != 0 && (calm || $urandom_range(0, 99) >= 20)) begin
          t = text_bytes_pending.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= t.text_byte;
          s_tlast  <= t.end_of_text;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure, each row transfer checked against the oldest due row
  always @(posedge clk) begin
    glyph_row_t want;
    m_tready <= calm || ($urandom_range(0, 99) >= 20);
    if (!rst && m_tvalid && m_tready) begin
      if (glyph_rows_due.size() == 0) begin
        report_mismatch($sformatf("unexpected row transfer tdata=%h tlast=%b", m_tdata, m_tlast));
      end else begin
        want = glyph_rows_due.pop_front();
        if (m_tdata[4:0] !== want.pixels)
          report_mismatch($sformatf("row_bits %h, want %h", m_tdata[4:0], want.pixels));
        if (m_tdata[7:5] !== want.row)
          report_mismatch($sformatf("row_index %0d, want %0d", m_tdata[7:5], want.row));
        if (m_tdata[8] !== want.dots)
          report_mismatch($sformatf("umlaut_dots %b, want %b", m_tdata[8], want.dots));
        if (m_tdata[15:9] !== 7'd0)
          report_mismatch($sformatf("tdata pad bits %h, want 0", m_tdata[15:9]));
        if (m_tlast !== want.final_row)
          report_mismatch($sformatf("last_row %b, want %b", m_tlast, want.final_row));
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int unsigned n_random;
    n_random = 0;

    // directed: glyph set edges, zero byte, no-glyph ASCII
    queue_byte(8'h61, 1'b0);   // 'a' folds to 'A'
    queue_byte(8'h25, 1'b0);
    queue_byte(8'h20, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h7F, 1'b0);
    // two-byte: umlaut upper, umlaut lower, micro sign without glyph
    queue_byte(8'hC3, 1'b0); queue_byte(8'h84, 1'b0);
    queue_byte(8'hC3, 1'b0); queue_byte(8'hB6, 1'b0);
    queue_byte(8'hC2, 1'b0); queue_byte(8'hB5, 1'b0);
    // three-byte: overlong 'A', then a code point above Latin-1
    queue_byte(8'hE0, 1'b0); queue_byte(8'h81, 1'b0); queue_byte(8'h81, 1'b0);
    queue_byte(8'hE2, 1'b0); queue_byte(8'h82, 1'b0); queue_byte(8'hAC, 1'b0);
    // bad lead bytes
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hFF, 1'b0);
    // text ends on a lead byte
    queue_byte(8'hC3, 1'b1);
    // text ends after two bytes of a three-byte sequence: ASCII, then high second byte
    queue_byte(8'hE2, 1'b0); queue_byte(8'h41, 1'b1);
    queue_byte(8'hEF, 1'b0); queue_byte(8'hC3, 1'b1);

    while (n_random < 410) queue_random_text(n_random);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (text_bytes_pending.size() != 0 || s_tvalid || glyph_rows_due.size() != 0);
    repeat (20) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
